// ===== rtl/core/xvbr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package xvbr_pkg;

    // Table of contents length of a standard header
    localparam int TOC_ENTRIES_DEF = 100;

    // Result kinds
    localparam logic [2:0] KIND_VERSION = 3'd0;
    localparam logic [2:0] KIND_FLAGS   = 3'd1;
    localparam logic [2:0] KIND_FRAMES  = 3'd2;
    localparam logic [2:0] KIND_BYTES   = 3'd3;
    localparam logic [2:0] KIND_TOC     = 3'd4;
    localparam logic [2:0] KIND_SCALE   = 3'd5;
    localparam logic [2:0] KIND_BAD_SIG = 3'd6;

    // Header signatures, big endian ASCII
    localparam logic [31:0] SIG_INFO = 32'h496E_666F;
    localparam logic [31:0] SIG_XING = 32'h5869_6E67;

    // One parsed result
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] value;
        logic [6:0]  toc_index;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/xvbr_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none

module xvbr_parse #(
    parameter int TOC_ENTRIES = xvbr_pkg::TOC_ENTRIES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_start,
    output logic                   o_res_valid,
    output xvbr_pkg::t_result      o_res
);
    import xvbr_pkg::*;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_SIG    = 3'd1;
    localparam logic [2:0] PH_FLAGS  = 3'd2;
    localparam logic [2:0] PH_FRAMES = 3'd3;
    localparam logic [2:0] PH_BYTES  = 3'd4;
    localparam logic [2:0] PH_TOC    = 3'd5;
    localparam logic [2:0] PH_SCALE  = 3'd6;

    localparam logic [7:0] TOC_LAST = 8'(TOC_ENTRIES - 1);

    // First optional-field phase at or after a flag bit, else idle
    function automatic logic [2:0] next_from(input logic [1:0] first, input logic [3:0] fp);
        logic [2:0] res;
        res = PH_IDLE;
        for (int b = 3; b >= 0; b--) begin
            if (b >= int'(first) && fp[b]) begin
                res = PH_FRAMES + 3'(b);
            end
        end
        return res;
    endfunction

    logic [2:0]  r_phase, n_phase;
    logic [6:0]  r_count, n_count;
    logic [23:0] r_word,  n_word;
    logic [3:0]  r_fp,    n_fp;

    logic [2:0]  ph;
    logic [6:0]  cnt;
    logic [23:0] word;
    logic [3:0]  fp;
    logic [31:0] full;
    logic [2:0]  nxt;

    // Step the parser on one byte
    always_comb begin
        ph   = i_start ? PH_SIG : r_phase;
        cnt  = i_start ? 7'd0   : r_count;
        word = i_start ? 24'd0  : r_word;
        fp   = i_start ? 4'd0   : r_fp;
        full = {word, i_data_byte};
        nxt  = PH_IDLE;

        n_phase     = r_phase;
        n_count     = r_count;
        n_word      = r_word;
        n_fp        = r_fp;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_en) begin
            n_phase = ph;
            n_count = cnt;
            n_word  = word;
            n_fp    = fp;
            case (ph)
                PH_TOC: begin
                    n_count = cnt + 7'd1;
                    if ({1'b0, cnt} >= TOC_LAST) begin
                        n_count = 7'd0;
                        nxt     = next_from(2'd3, fp);
                        n_phase = nxt;
                    end
                    o_res_valid     = 1'b1;
                    o_res.kind      = KIND_TOC;
                    o_res.value     = {24'd0, i_data_byte};
                    o_res.toc_index = cnt;
                    o_res.last      = (n_phase == PH_IDLE);
                end
                PH_SIG, PH_FLAGS, PH_FRAMES, PH_BYTES, PH_SCALE: begin
                    if (cnt < 7'd3) begin
                        // Shift in a partial field byte
                        n_word  = full[23:0];
                        n_count = cnt + 7'd1;
                    end else begin
                        n_word      = 24'd0;
                        n_count     = 7'd0;
                        o_res_valid = 1'b1;
                        o_res.value = full;
                        case (ph)
                            PH_SIG: begin
                                if (full == SIG_INFO || full == SIG_XING) begin
                                    n_phase     = PH_FLAGS;
                                    o_res.kind  = KIND_VERSION;
                                    o_res.value = {31'd0, full == SIG_XING};
                                    o_res.last  = 1'b0;
                                end else begin
                                    n_phase     = PH_IDLE;
                                    o_res.kind  = KIND_BAD_SIG;
                                    o_res.value = 32'd0;
                                    o_res.last  = 1'b1;
                                end
                            end
                            PH_FLAGS: begin
                                n_fp       = full[3:0];
                                nxt        = next_from(2'd0, full[3:0]);
                                n_phase    = nxt;
                                o_res.kind = KIND_FLAGS;
                                o_res.last = (nxt == PH_IDLE);
                            end
                            PH_FRAMES: begin
                                nxt        = next_from(2'd1, fp);
                                n_phase    = nxt;
                                o_res.kind = KIND_FRAMES;
                                o_res.last = (nxt == PH_IDLE);
                            end
                            PH_BYTES: begin
                                nxt        = next_from(2'd2, fp);
                                n_phase    = nxt;
                                o_res.kind = KIND_BYTES;
                                o_res.last = (nxt == PH_IDLE);
                            end
                            default: begin
                                n_phase    = PH_IDLE;
                                o_res.kind = KIND_SCALE;
                                o_res.last = 1'b1;
                            end
                        endcase
                    end
                end
                default: begin
                    // Idle: drop the byte
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // Hold parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= 7'd0;
            r_word  <= 24'd0;
            r_fp    <= 4'd0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_word  <= n_word;
            r_fp    <= n_fp;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/xing_vbr_header_parser.sv =====
// Xing / Info VBR header parser.
// Slave stream: one header byte per transfer; tuser set marks the first
// byte of a header and restarts the parse. Master stream: one transfer
// per completed field (version, flags, frame count, byte size, each table
// of contents byte, VBR scale, or a bad-signature report); tlast marks the
// transfer that ends the header or reports a bad signature.
// An accepted byte waits in the input register, is parsed into the result
// register when that register can take it, and is offered from there.
// Throughput: one byte per cycle while the receiver does not stall, set by
// the single parse step between the two registers. Bytes that finish no
// field produce no transfer.
// Reset (synchronous, active low) empties both registers and returns the
// parser to idle; bytes without a start mark are then dropped.
// When the receiver stalls, the result register holds its transfer and
// the input register fills, after which s_tready drops; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module xing_vbr_header_parser #(
    parameter int TOC_ENTRIES = xvbr_pkg::TOC_ENTRIES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  wire logic [0:0]  i_s_tuser,   // [0] start_req
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [39:0]      o_m_tdata,   // [31:0] value, [38:32] toc_index, [39] zero
    output logic [2:0]       o_m_tuser,   // [2:0] kind
    output logic             o_m_tlast    // last
);
    import xvbr_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_start;
    logic        r_out_valid;
    t_result     r_out;

    logic        s1_adv;
    logic        res_valid;
    t_result     res;

    // Advance the input register when the result register can take it
    assign s1_adv     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || s1_adv;

    // Hold the accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte  <= i_s_tdata;
            r_in_start <= i_s_tuser[0];
        end
    end

    xvbr_parse #(
        .TOC_ENTRIES (TOC_ENTRIES)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (s1_adv),
        .i_data_byte (r_in_byte),
        .i_start     (r_in_start),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Load or drain the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= res_valid;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out.toc_index, r_out.value};
    assign o_m_tuser  = r_out.kind;
    assign o_m_tlast  = r_out.last;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import xvbr_pkg::*;

    // Parser phases of the behavioral parser
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SIG,
        PH_FLAGS,
        PH_FRAMES,
        PH_BYTES,
        PH_TOC,
        PH_SCALE
    } t_parse_phase;

    // One row of the directed byte table
    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       typed;
        t_result    want;
    } t_byte_row;

    localparam int TOC_LEN      = TOC_ENTRIES_DEF;
    localparam int LIVE_TARGET  = 900;
    localparam int HOLD_CYCLES  = 300;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = 8'd0;   // [7:0] data_byte
    logic [0:0]  i_s_tuser  = 1'b0;   // [0] start_req
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;           // [31:0] value, [38:32] toc_index, [39] zero
    logic [2:0]  o_m_tuser;           // [2:0] kind
    logic        o_m_tlast;

    // Behavioral parser state
    t_parse_phase hp_phase;
    logic [6:0]   hp_count;
    logic [31:0]  hp_word;
    logic [3:0]   hp_fields;

    t_result     pending_fields[$];
    t_byte_row   byte_table[$];
    logic [7:0]  hdr_bytes[$];

    int  errors      = 0;
    int  live_items  = 0;
    int  kind_seen[8];
    bit  tx_pause_on = 1'b1;
    bit  rx_pause_on = 1'b1;
    bit  hold_req    = 1'b0;
    int  holds_done  = 0;

    xing_vbr_header_parser i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Generous bound on the whole run
    initial begin
        #2_000_000;
        $display("%0t timeout, %0d results still expected", $time, pending_fields.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // First optional field at or above the given flag bit, else idle
    function automatic t_parse_phase field_after(input int bit_pos);
        for (int b = bit_pos; b < 4; b++) begin
            if (hp_fields[b]) begin
                return t_parse_phase'(PH_FRAMES + b);
            end
        end
        return PH_IDLE;
    endfunction

    // Advance the parser by one byte; return 1 when a field completes
    function automatic bit predict_field(input logic [7:0] b, input logic start,
                                         output t_result res);
        int          idx;
        logic [31:0] w;
        res = '0;
        if (start) begin
            hp_phase  = PH_SIG;
            hp_count  = '0;
            hp_word   = '0;
            hp_fields = '0;
        end
        if (hp_phase == PH_IDLE) begin
            return 1'b0;
        end
        // Table of contents: one result per byte
        if (hp_phase == PH_TOC) begin
            idx      = int'(hp_count);
            hp_count = hp_count + 7'd1;
            if (idx + 1 >= TOC_LEN) begin
                hp_count = '0;
                hp_phase = field_after(3);
            end
            res.kind      = KIND_TOC;
            res.value     = {24'd0, b};
            res.toc_index = idx[6:0];
            res.last      = (hp_phase == PH_IDLE);
            return 1'b1;
        end
        // Four-byte big-endian fields
        hp_word  = {hp_word[23:0], b};
        hp_count = hp_count + 7'd1;
        if (hp_count < 7'd4) begin
            return 1'b0;
        end
        w        = hp_word;
        hp_count = '0;
        hp_word  = '0;
        res.value = w;
        case (hp_phase)
            PH_SIG: begin
                if (w == SIG_INFO || w == SIG_XING) begin
                    hp_phase  = PH_FLAGS;
                    res.kind  = KIND_VERSION;
                    res.value = (w == SIG_XING) ? 32'd1 : 32'd0;
                end else begin
                    hp_phase  = PH_IDLE;
                    res.kind  = KIND_BAD_SIG;
                    res.value = '0;
                    res.last  = 1'b1;
                end
            end
            PH_FLAGS: begin
                hp_fields = w[3:0];
                hp_phase  = field_after(0);
                res.kind  = KIND_FLAGS;
                res.last  = (hp_phase == PH_IDLE);
            end
            PH_FRAMES: begin
                hp_phase = field_after(1);
                res.kind = KIND_FRAMES;
                res.last = (hp_phase == PH_IDLE);
            end
            PH_BYTES: begin
                hp_phase = field_after(2);
                res.kind = KIND_BYTES;
                res.last = (hp_phase == PH_IDLE);
            end
            default: begin
                hp_phase = PH_IDLE;
                res.kind = KIND_SCALE;
                res.last = 1'b1;
            end
        endcase
        return 1'b1;
    endfunction

    function automatic void add_row(input logic [7:0] d, input logic s, input logic typed,
                                    input logic [2:0] k, input logic [31:0] v,
                                    input logic l);
        t_byte_row r;
        r.data           = d;
        r.start          = s;
        r.typed          = typed;
        r.want.kind      = k;
        r.want.value     = v;
        r.want.toc_index = '0;
        r.want.last      = l;
        byte_table.push_back(r);
    endfunction

    function automatic void push_be(input logic [31:0] w);
        for (int i = 3; i >= 0; i--) begin
            hdr_bytes.push_back(w[8*i +: 8]);
        end
    endfunction

    function automatic logic [31:0] draw_word();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Offer one byte, wait for the transfer, then record what it should produce
    task automatic send_byte(input logic [7:0] d, input logic s, input logic typed,
                             input t_result want);
        int      gap;
        bit      live;
        bit      has;
        t_result got;
        gap = tx_pause_on ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        i_s_tuser  <= s;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        live = s || (hp_phase != PH_IDLE);
        has  = predict_field(d, s, got);
        if (live) begin
            live_items++;
        end
        if (typed) begin
            pending_fields.push_back(want);
        end else if (has) begin
            pending_fields.push_back(got);
        end
    endtask

    // Build one header; optionally cut it short or break its signature
    task automatic send_header(input bit cut, input bit bad_sig);
        logic [31:0] sig;
        logic [31:0] flags;
        int          keep;
        hdr_bytes.delete();
        if (bad_sig) begin
            sig = $urandom;
            if ($urandom_range(0, 1)) begin
                sig = ($urandom_range(0, 1) ? SIG_XING : SIG_INFO)
                      ^ (32'd1 << $urandom_range(0, 31));
            end
            if (sig == SIG_INFO || sig == SIG_XING) begin
                sig = ~sig;
            end
        end else begin
            sig = $urandom_range(0, 1) ? SIG_XING : SIG_INFO;
        end
        push_be(sig);
        if (!bad_sig) begin
            flags = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
            flags[3:0] = 4'($urandom_range(0, 15));
            // Keep the long table of contents to about a sixth of the headers
            if (flags[2] && $urandom_range(0, 2) != 0) begin
                flags[2] = 1'b0;
            end
            push_be(flags);
            if (flags[0]) push_be(draw_word());
            if (flags[1]) push_be(draw_word());
            if (flags[2]) begin
                for (int i = 0; i < TOC_LEN; i++) begin
                    hdr_bytes.push_back(8'($urandom_range(0, 255)));
                end
            end
            if (flags[3]) push_be(draw_word());
        end
        keep = cut ? $urandom_range(1, hdr_bytes.size() - 1) : hdr_bytes.size();
        for (int i = 0; i < keep; i++) begin
            send_byte(hdr_bytes[i], i == 0, 1'b0, '0);
        end
    endtask

    // Result side: random stalls, plus long hold-offs on request
    initial begin
        int stall;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                holds_done++;
            end
            stall = rx_pause_on ? $urandom_range(0, 7) : 0;
            if (stall != 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
        end
    end

    task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t %s mismatch: expected %0h, actual %0h", $time, field, want, got);
            errors++;
        end
    endtask

    // Compare each result transfer with the oldest expected field
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_fields.size() == 0) begin
                $display("%0t unexpected result: kind %0d value %0h index %0d last %0b",
                         $time, o_m_tuser, o_m_tdata[31:0], o_m_tdata[38:32], o_m_tlast);
                errors++;
            end else begin
                want = pending_fields.pop_front();
                report("kind", {29'd0, want.kind}, {29'd0, o_m_tuser});
                report("value", want.value, o_m_tdata[31:0]);
                report("toc_index", {25'd0, want.toc_index}, {25'd0, o_m_tdata[38:32]});
                report("last", {31'd0, want.last}, {31'd0, o_m_tlast});
                kind_seen[o_m_tuser]++;
            end
        end
    end

    // Stimulus
    initial begin
        int choice;
        hp_phase  = PH_IDLE;
        hp_count  = '0;
        hp_word   = '0;
        hp_fields = '0;

        // Directed bytes: data, start, typed, kind, value, last
        add_row(8'h00, 1'b0, 1'b0, KIND_VERSION, 32'd0, 1'b0);  // idle after reset
        add_row(8'h58, 1'b1, 1'b0, KIND_VERSION, 32'd0, 1'b0);  // X
        add_row(8'h69, 1'b0, 1'b0, KIND_VERSION, 32'd0, 1'b0);
        add_row(8'h6E, 1'b0, 1'b0, KIND_VERSION, 32'd0, 1'b0);
        add_row(8'h67, 1'b0, 1'b1, KIND_VERSION, 32'd1, 1'b0);
        add_row(8'hFF, 1'b0, 1'b0, KIND_VERSION, 32'd0, 1'b0);  // upper flags only
        add_row(8'hFF, 1'b0, 1'b0, KIND_VERSION, 32'd0, 1'b0);
        add_row(8'hFF, 1'b0, 1'b0, KIND_VERSION, 32'd0, 1'b0);
        add_row(8'hF0, 1'b0, 1'b1, KIND_FLAGS, 32'hFFFF_FFF0, 1'b1);
        add_row(8'h49, 1'b1, 1'b0, KIND_VERSION, 32'd0, 1'b0);  // I
        add_row(8'h6E, 1'b0, 1'b0, KIND_VERSION, 32'd0, 1'b0);
        add_row(8'h66, 1'b0, 1'b0, KIND_VERSION, 32'd0, 1'b0);
        add_row(8'h6F, 1'b0, 1'b1, KIND_VERSION, 32'd0, 1'b0);
        add_row(8'h00, 1'b0, 1'b0, KIND_VERSION, 32'd0, 1'b0);  // flags left unfinished
        add_row(8'h58, 1'b1, 1'b0, KIND_VERSION, 32'd0, 1'b0);  // restart mid-header
        add_row(8'h69, 1'b0, 1'b0, KIND_VERSION, 32'd0, 1'b0);
        add_row(8'h6E, 1'b0, 1'b0, KIND_VERSION, 32'd0, 1'b0);
        add_row(8'h67, 1'b0, 1'b1, KIND_VERSION, 32'd1, 1'b0);
        add_row(8'h00, 1'b0, 1'b0, KIND_VERSION, 32'd0, 1'b0);  // scale only
        add_row(8'h00, 1'b0, 1'b0, KIND_VERSION, 32'd0, 1'b0);
        add_row(8'h00, 1'b0, 1'b0, KIND_VERSION, 32'd0, 1'b0);
        add_row(8'h08, 1'b0, 1'b1, KIND_FLAGS, 32'h0000_0008, 1'b0);
        add_row(8'hFF, 1'b0, 1'b0, KIND_VERSION, 32'd0, 1'b0);
        add_row(8'hFF, 1'b0, 1'b0, KIND_VERSION, 32'd0, 1'b0);
        add_row(8'hFF, 1'b0, 1'b0, KIND_VERSION, 32'd0, 1'b0);
        add_row(8'hFF, 1'b0, 1'b1, KIND_SCALE, 32'hFFFF_FFFF, 1'b1);
        add_row(8'h51, 1'b1, 1'b0, KIND_VERSION, 32'd0, 1'b0);  // bad signature
        add_row(8'h00, 1'b0, 1'b0, KIND_VERSION, 32'd0, 1'b0);
        add_row(8'h00, 1'b0, 1'b0, KIND_VERSION, 32'd0, 1'b0);
        add_row(8'h00, 1'b0, 1'b1, KIND_BAD_SIG, 32'd0, 1'b1);
        add_row(8'h7E, 1'b0, 1'b0, KIND_VERSION, 32'd0, 1'b0);  // idle after bad signature

        // Hold reset, then release it
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (byte_table[i]) begin
            send_byte(byte_table[i].data, byte_table[i].start, byte_table[i].typed,
                      byte_table[i].want);
        end

        // Random headers, mostly well formed, with noise and broken ones mixed in
        while (live_items < LIVE_TARGET) begin
            if ($urandom_range(0, 9) == 0) begin
                tx_pause_on = ($urandom_range(0, 2) != 0);
                rx_pause_on = ($urandom_range(0, 2) != 0);
            end
            if (!hold_req && holds_done < 2 && live_items > 300 * (holds_done + 1)) begin
                hold_req = 1'b1;
            end
            choice = $urandom_range(0, 9);
            case (choice)
                0: begin
                    repeat ($urandom_range(1, 6)) begin
                        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                                  1'b0, '0);
                    end
                end
                1:       send_header(1'b1, 1'b0);
                2:       send_header(1'b0, 1'b1);
                default: send_header(1'b0, 1'b0);
            endcase
        end
        i_s_tvalid <= 1'b0;

        // Drain, then allow the pipeline latency to pass
        while (pending_fields.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Covered %0d parsed bytes: %0d versions, %0d flags, %0d frame counts, %0d sizes",
                 live_items, kind_seen[KIND_VERSION], kind_seen[KIND_FLAGS],
                 kind_seen[KIND_FRAMES], kind_seen[KIND_BYTES]);
        $display("  %0d toc entries, %0d scales, %0d bad signatures, %0d long output holds",
                 kind_seen[KIND_TOC], kind_seen[KIND_SCALE], kind_seen[KIND_BAD_SIG],
                 holds_done);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
